[hdl/wss_pkg.sv]
// Shared types and constants of the work-stealing task scheduler.
package wss_pkg;

	localparam int CNT_W   = 48;
	localparam int TRIED_W = 5;
	localparam int LEN_W   = 11;
	localparam int TID_W   = 3;
	localparam int CFG_W   = 3;
	localparam int VIC_W   = 2;
	localparam int TCNT_W  = 5;
	localparam int N_CNT   = 5;

	typedef enum logic [1:0] {
		OP_SPAWN = 2'd0,
		OP_FETCH = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SRC_NONE   = 2'd0,
		SRC_OWN    = 2'd1,
		SRC_STOLEN = 2'd2,
		SRC_GLOBAL = 2'd3
	} src_t;

	typedef enum logic [1:0] {
		PLACE_NONE   = 2'd0,
		PLACE_OWN    = 2'd1,
		PLACE_GLOBAL = 2'd2,
		PLACE_DROP   = 2'd3
	} place_t;

	typedef struct packed {
		logic               clear;
		logic               steal;
		logic [TRIED_W-1:0] tried;
		logic               global_take;
		logic               busy;
		logic               idle;
	} metric_upd_t;

endpackage

[hdl/wss_ram.sv]
// Single-port-write, registered-read handle memory.
module wss_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 32,
	parameter int AW    = 12
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/wss_metrics.sv]
// Saturating metric counters of the scheduler.
module wss_metrics import wss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd_en,
	input  metric_upd_t       upd,
	output logic [CNT_W-1:0]  steals_done,
	output logic [CNT_W-1:0]  steals_tried,
	output logic [CNT_W-1:0]  global_taken,
	output logic [CNT_W-1:0]  busy_count,
	output logic [CNT_W-1:0]  idle_count
);

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	logic [CNT_W-1:0] cnt_q [N_CNT];
	logic [CNT_W-1:0] cnt_d [N_CNT];
	logic [CNT_W-1:0] inc   [N_CNT];

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
			input logic [CNT_W-1:0] k);
		return (c > CNT_MAX - k) ? CNT_MAX : c + k;
	endfunction

	always_comb begin
		inc[0] = CNT_W'(upd.steal);
		inc[1] = CNT_W'(upd.tried);
		inc[2] = CNT_W'(upd.global_take);
		inc[3] = CNT_W'(upd.busy);
		inc[4] = CNT_W'(upd.idle);
		for (int i = 0; i < N_CNT; i++) begin
			if (!upd_en) begin
				cnt_d[i] = cnt_q[i];
			end else if (upd.clear) begin
				cnt_d[i] = '0;
			end else begin
				cnt_d[i] = sat_add(cnt_q[i], inc[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_CNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < N_CNT; i++) begin
				cnt_q[i] <= cnt_d[i];
			end
		end
	end

	assign steals_done  = cnt_q[0];
	assign steals_tried = cnt_q[1];
	assign global_taken = cnt_q[2];
	assign busy_count   = cnt_q[3];
	assign idle_count   = cnt_q[4];

endmodule

[hdl/work_stealing_task_scheduler_core.sv]
// Top level of the work-stealing task scheduler.
// Requests enter on req_valid/req_stall; one word is taken at an edge where
// req_valid is high and req_stall is low. Each request is a spawn, a fetch, a
// clear of the metric counters or a no-op, and each gives exactly one response
// word on rsp_valid/rsp_stall. The deque pointers and FIFO pointers sit in
// registers and are updated at the accepting edge; the slot memories are
// written or read at that edge as well. The read data and the first stage
// (valid_s1) are registered there, and the response register is loaded from
// them when it is not stalled. No new request is taken while the first stage
// holds a word or the response register is stalled; a stalled response
// register holds its word. The counters shown with a response are those left
// by that request. Reset empties every deque and the FIFO, zeroes the counters
// and sets active_threads to four; the slot memories are not cleared and need
// no pass after reset. active_threads is written through cfg_wr_en/cfg_wr_data
// by the user only while the block is idle; the block does not enforce this.
module work_stealing_task_scheduler_core import wss_pkg::*; #(
	parameter int THREADS      = 4,
	parameter int DEQUE_DEPTH  = 1024,
	parameter int GLOBAL_DEPTH = 4096,
	parameter int HANDLE_BITS  = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_W-1:0]       cfg_wr_data,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic [1:0]             operation,
	input  logic [TID_W-1:0]       thread_index,
	input  logic [HANDLE_BITS-1:0] task_handle,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output logic                   task_valid,
	output logic [HANDLE_BITS-1:0] task_out,
	output logic [1:0]             task_source,
	output logic [VIC_W-1:0]       victim_thread,
	output logic [1:0]             spawn_place,
	output logic [LEN_W-1:0]       own_length,
	output logic [CNT_W-1:0]       steals_done,
	output logic [CNT_W-1:0]       steals_tried,
	output logic [CNT_W-1:0]       global_taken,
	output logic [CNT_W-1:0]       busy_count,
	output logic [CNT_W-1:0]       idle_count
);

	localparam int TIW = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int DSW = $clog2(DEQUE_DEPTH);
	localparam int DPW = $clog2(2 * DEQUE_DEPTH);
	localparam int GSW = $clog2(GLOBAL_DEPTH);
	localparam int GPW = $clog2(2 * GLOBAL_DEPTH);
	localparam int DAW = $clog2(THREADS * DEQUE_DEPTH);
	localparam logic [TCNT_W-1:0] THREADS_C = TCNT_W'(THREADS);

	function automatic logic [DPW-1:0] dq_inc(input logic [DPW-1:0] p);
		return (int'(p) + 1 >= 2 * DEQUE_DEPTH) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [DPW-1:0] dq_dec(input logic [DPW-1:0] p);
		return (p == '0) ? DPW'(2 * DEQUE_DEPTH - 1) : p - 1'b1;
	endfunction

	function automatic logic [DSW-1:0] dq_slot(input logic [DPW-1:0] p);
		return (int'(p) >= DEQUE_DEPTH) ? DSW'(p - DPW'(DEQUE_DEPTH)) : DSW'(p);
	endfunction

	function automatic logic [DPW-1:0] dq_fill(input logic [DPW-1:0] t,
			input logic [DPW-1:0] b);
		return (b >= t) ? b - t : DPW'(int'(b) + 2 * DEQUE_DEPTH - int'(t));
	endfunction

	function automatic logic [GPW-1:0] gq_inc(input logic [GPW-1:0] p);
		return (int'(p) + 1 >= 2 * GLOBAL_DEPTH) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [GSW-1:0] gq_slot(input logic [GPW-1:0] p);
		return (int'(p) >= GLOBAL_DEPTH) ? GSW'(p - GPW'(GLOBAL_DEPTH)) : GSW'(p);
	endfunction

	function automatic logic [DAW-1:0] dq_addr(input logic [TIW-1:0] d,
			input logic [DSW-1:0] s);
		return DAW'(DAW'(d) * DAW'(DEQUE_DEPTH)) + DAW'(s);
	endfunction

	logic [CFG_W-1:0]  active_q;
	logic [DPW-1:0]    top_q [THREADS];
	logic [DPW-1:0]    bot_q [THREADS];
	logic [GPW-1:0]    ghead_q;
	logic [GPW-1:0]    gtail_q;

	logic              valid_s1;
	src_t              src_s1;
	place_t            place_s1;
	logic [VIC_W-1:0]  victim_s1;
	logic [LEN_W-1:0]  len_s1;

	logic                   rsp_valid_q;
	logic                   task_valid_q;
	logic [HANDLE_BITS-1:0] task_out_q;
	src_t                   src_q;
	logic [VIC_W-1:0]       victim_q;
	place_t                 place_q;
	logic [LEN_W-1:0]       len_q;

	op_t               op;
	logic              acc;
	logic              advance;
	logic [TCNT_W-1:0] n_eff;
	logic              worker;
	logic [TIW-1:0]    me;
	logic [DPW-1:0]    fill [THREADS];
	logic [DPW-1:0]    own_fill;
	logic              own_full;
	logic              own_empty;
	logic              found;
	logic [TIW-1:0]    vic;
	logic [TRIED_W-1:0] tried;
	logic [GPW-1:0]    gfill;
	logic              gfull;
	logic              gempty;

	src_t              src_d;
	place_t            place_d;
	logic [LEN_W-1:0]  len_d;
	metric_upd_t       upd;

	logic                   dq_we;
	logic                   dq_re;
	logic [DAW-1:0]         dq_waddr;
	logic [DAW-1:0]         dq_raddr;
	logic [HANDLE_BITS-1:0] dq_rdata;
	logic                   gq_we;
	logic                   gq_re;
	logic [GSW-1:0]         gq_waddr;
	logic [GSW-1:0]         gq_raddr;
	logic [HANDLE_BITS-1:0] gq_rdata;

	assign op        = op_t'(operation);
	assign req_stall = valid_s1 | (rsp_valid_q & rsp_stall);
	assign acc       = req_valid & ~req_stall;
	assign advance   = valid_s1 & ~(rsp_valid_q & rsp_stall);

	always_comb begin
		if (active_q == '0) begin
			n_eff = TCNT_W'(1);
		end else if (TCNT_W'(active_q) > THREADS_C) begin
			n_eff = THREADS_C;
		end else begin
			n_eff = TCNT_W'(active_q);
		end
	end

	assign worker = TCNT_W'(thread_index) < n_eff;
	assign me     = TIW'(thread_index);

	always_comb begin
		for (int i = 0; i < THREADS; i++) begin
			fill[i] = dq_fill(top_q[i], bot_q[i]);
		end
	end

	assign own_fill  = worker ? fill[me] : '0;
	assign own_full  = int'(own_fill) >= DEQUE_DEPTH;
	assign own_empty = own_fill == '0;

	always_comb begin
		found = 1'b0;
		vic   = '0;
		tried = '0;
		for (int i = 0; i < THREADS; i++) begin
			if (!found && TCNT_W'(i) < n_eff && i != int'(thread_index)) begin
				tried = tried + 1'b1;
				if (fill[i] != '0) begin
					found = 1'b1;
					vic   = TIW'(i);
				end
			end
		end
	end

	assign gfill  = (gtail_q >= ghead_q) ? gtail_q - ghead_q
		: GPW'(int'(gtail_q) + 2 * GLOBAL_DEPTH - int'(ghead_q));
	assign gfull  = int'(gfill) >= GLOBAL_DEPTH;
	assign gempty = ghead_q == gtail_q;

	always_comb begin
		src_d    = SRC_NONE;
		place_d  = PLACE_NONE;
		len_d    = LEN_W'(own_fill);
		upd      = '0;
		dq_we    = 1'b0;
		dq_re    = 1'b0;
		dq_waddr = dq_addr(me, dq_slot(worker ? bot_q[me] : '0));
		dq_raddr = dq_addr(me, dq_slot(dq_dec(worker ? bot_q[me] : '0)));
		gq_we    = 1'b0;
		gq_re    = 1'b0;
		gq_waddr = gq_slot(gtail_q);
		gq_raddr = gq_slot(ghead_q);
		unique case (op)
			OP_SPAWN: begin
				if (worker && !own_full) begin
					place_d = PLACE_OWN;
					dq_we   = 1'b1;
					len_d   = LEN_W'(own_fill + 1'b1);
				end else if (!gfull) begin
					place_d = PLACE_GLOBAL;
					gq_we   = 1'b1;
				end else begin
					place_d = PLACE_DROP;
				end
			end
			OP_FETCH: begin
				if (worker && !own_empty) begin
					src_d = SRC_OWN;
					dq_re = 1'b1;
					len_d = LEN_W'(own_fill - 1'b1);
				end else begin
					upd.tried = tried;
					if (found) begin
						src_d     = SRC_STOLEN;
						dq_re     = 1'b1;
						dq_raddr  = dq_addr(vic, dq_slot(top_q[vic]));
						upd.steal = 1'b1;
					end else if (!gempty) begin
						src_d           = SRC_GLOBAL;
						gq_re           = 1'b1;
						upd.global_take = 1'b1;
					end
				end
				upd.busy = src_d != SRC_NONE;
				upd.idle = src_d == SRC_NONE;
			end
			OP_CLEAR: begin
				upd.clear = 1'b1;
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CFG_W'(4);
		end else if (cfg_wr_en) begin
			active_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREADS; i++) begin
				top_q[i] <= '0;
				bot_q[i] <= '0;
			end
			ghead_q <= '0;
			gtail_q <= '0;
		end else if (acc) begin
			if (dq_we) begin
				bot_q[me] <= dq_inc(bot_q[me]);
			end
			if (src_d == SRC_OWN) begin
				bot_q[me] <= dq_dec(bot_q[me]);
			end
			if (src_d == SRC_STOLEN) begin
				top_q[vic] <= dq_inc(top_q[vic]);
			end
			if (gq_we) begin
				gtail_q <= gq_inc(gtail_q);
			end
			if (gq_re) begin
				ghead_q <= gq_inc(ghead_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			src_s1    <= src_d;
			place_s1  <= place_d;
			victim_s1 <= (src_d == SRC_STOLEN) ? VIC_W'(vic) : '0;
			len_s1    <= len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			task_valid_q <= src_s1 != SRC_NONE;
			src_q        <= src_s1;
			victim_q     <= victim_s1;
			place_q      <= place_s1;
			len_q        <= len_s1;
			case (src_s1) inside
				SRC_OWN, SRC_STOLEN: task_out_q <= dq_rdata;
				SRC_GLOBAL:          task_out_q <= gq_rdata;
				default:             task_out_q <= '0;
			endcase
		end
	end

	wss_ram #(
		.DEPTH (THREADS * DEQUE_DEPTH),
		.WIDTH (HANDLE_BITS),
		.AW    (DAW)
	) u_deque_ram (
		.clk   (clk),
		.we    (acc & dq_we),
		.waddr (dq_waddr),
		.wdata (task_handle),
		.re    (acc & dq_re),
		.raddr (dq_raddr),
		.rdata (dq_rdata)
	);

	wss_ram #(
		.DEPTH (GLOBAL_DEPTH),
		.WIDTH (HANDLE_BITS),
		.AW    (GSW)
	) u_global_ram (
		.clk   (clk),
		.we    (acc & gq_we),
		.waddr (gq_waddr),
		.wdata (task_handle),
		.re    (acc & gq_re),
		.raddr (gq_raddr),
		.rdata (gq_rdata)
	);

	wss_metrics u_metrics (
		.clk          (clk),
		.arst_n       (arst_n),
		.upd_en       (acc),
		.upd          (upd),
		.steals_done  (steals_done),
		.steals_tried (steals_tried),
		.global_taken (global_taken),
		.busy_count   (busy_count),
		.idle_count   (idle_count)
	);

	assign rsp_valid     = rsp_valid_q;
	assign task_valid    = task_valid_q;
	assign task_out      = task_out_q;
	assign task_source   = src_q;
	assign victim_thread = victim_q;
	assign spawn_place   = place_q;
	assign own_length    = len_q;

`ifndef SYNTHESIS
	a_acc_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> valid_s1)
		else $error("Accepted word did not reach the first stage.");

	a_s1_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid && !valid_s1)
		else $error("First stage did not move into the response register.");

	a_task_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && task_valid |-> src_q != SRC_NONE && place_q == PLACE_NONE)
		else $error("Returned task without a source, or on a spawn.");

	a_steal_victim: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && src_q != SRC_STOLEN |-> victim_q == '0)
		else $error("Victim reported without a steal.");
`endif

endmodule
